// ===== rtl/aldc_pkg.sv =====
`default_nettype none
package aldc_pkg;

  localparam int LINE_MAX  = 32;
  localparam int IDX_W     = $clog2(LINE_MAX);
  localparam int LEN_W     = $clog2(LINE_MAX + 1);
  localparam int ADDR_W    = IDX_W + 1;
  localparam int COUNT_W   = 16;
  localparam logic [7:0] NEWLINE = 8'd10;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic store_byte;
    logic promote;
    logic count_inc;
    logic clear_all;
    logic idx_clear;
    logic idx_inc;
    logic rd_prev;
  } aldc_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic is_newline;
    logic cur_len_zero;
    logic have_prev;
    logic len_mismatch;
    logic pair_differ;
    logic idx_last_cmp;
    logic idx_last_emit;
  } aldc_status_t;

endpackage
`default_nettype wire

// ===== rtl/adjacent_line_dedup_counter.sv =====
`default_nettype none
// Counts runs of adjacent equal text lines. Bytes come in one per beat and are
// stored in one bank of a 64-byte line store while the previous line sits in the
// other bank; a newline (or the end marker with a pending line) completes the line.
// A byte is stored when it is accepted. A completed line of the same length as the
// previous one is compared byte by byte, and a group that is emitted reads each
// result byte from the registered line store and then presents the beat, holding
// it while out_ready is low. Input is accepted only while no line is being
// compared or emitted. Lines longer than 32 bytes are truncated and the repeat
// count saturates at 65535; an empty line gives one beat with byte_valid low.
// After the end marker the block is back in its reset state.
module adjacent_line_dedup_counter (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      in_valid,
  output logic                           in_ready,
  input  wire logic [7:0]                ch,
  input  wire logic                      end_of_input,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic [aldc_pkg::COUNT_W-1:0]   repeat_count,
  output logic [7:0]                     text_byte,
  output logic                           byte_valid,
  output logic                           group_last
);

  aldc_pkg::aldc_cmd_t    cmd;
  aldc_pkg::aldc_status_t status;

  aldc_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .end_of_input (end_of_input),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .cmd          (cmd)
  );

  aldc_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .ch           (ch),
    .cmd          (cmd),
    .status       (status),
    .repeat_count (repeat_count),
    .text_byte    (text_byte),
    .byte_valid   (byte_valid),
    .group_last   (group_last)
  );

endmodule
`default_nettype wire

// ===== rtl/aldc_dp.sv =====
`default_nettype none
module aldc_dp (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic [7:0]                     ch,
  input  wire aldc_pkg::aldc_cmd_t            cmd,
  output aldc_pkg::aldc_status_t              status,
  output logic [aldc_pkg::COUNT_W-1:0]        repeat_count,
  output logic [7:0]                          text_byte,
  output logic                                byte_valid,
  output logic                                group_last
);

  logic [7:0] line_store [2**aldc_pkg::ADDR_W];

  logic                          bank_select;
  logic [aldc_pkg::LEN_W-1:0]    previous_length;
  logic [aldc_pkg::LEN_W-1:0]    current_length;
  logic [aldc_pkg::COUNT_W-1:0]  group_count;
  logic                          have_previous;
  logic [aldc_pkg::IDX_W-1:0]    idx;
  logic [7:0]                    rd_a;
  logic [7:0]                    rd_b;

  logic [aldc_pkg::ADDR_W-1:0]   wr_addr;
  logic [aldc_pkg::ADDR_W-1:0]   addr_a;
  logic [aldc_pkg::ADDR_W-1:0]   addr_b;
  logic                          wr_en;
  logic [aldc_pkg::LEN_W-1:0]    idx_plus1;

  assign wr_addr   = {bank_select, current_length[aldc_pkg::IDX_W-1:0]};
  assign wr_en     = cmd.store_byte &&
                     (current_length < aldc_pkg::LEN_W'(aldc_pkg::LINE_MAX));
  // Port A reads the current bank while comparing and the previous bank while emitting.
  assign addr_a    = {cmd.rd_prev ? ~bank_select : bank_select, idx};
  assign addr_b    = {~bank_select, idx};
  assign idx_plus1 = {1'b0, idx} + aldc_pkg::LEN_W'(1);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_store[wr_addr] <= ch;
    end
    rd_a <= line_store[addr_a];
    rd_b <= line_store[addr_b];
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_all) begin
      bank_select     <= 1'b0;
      previous_length <= '0;
      current_length  <= '0;
      group_count     <= aldc_pkg::COUNT_W'(1);
      have_previous   <= 1'b0;
    end else if (cmd.promote) begin
      previous_length <= current_length;
      bank_select     <= ~bank_select;
      current_length  <= '0;
      group_count     <= aldc_pkg::COUNT_W'(1);
      have_previous   <= 1'b1;
    end else if (cmd.count_inc) begin
      if (group_count != aldc_pkg::COUNT_MAX) begin
        group_count <= group_count + aldc_pkg::COUNT_W'(1);
      end
      current_length <= '0;
    end else if (wr_en) begin
      current_length <= current_length + aldc_pkg::LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.idx_clear) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + aldc_pkg::IDX_W'(1);
    end
  end

  always_comb begin
    status.is_newline    = (ch == aldc_pkg::NEWLINE);
    status.cur_len_zero  = (current_length == '0);
    status.have_prev     = have_previous;
    status.len_mismatch  = (previous_length != current_length);
    status.pair_differ   = (rd_a != rd_b);
    status.idx_last_cmp  = (idx_plus1 == current_length);
    status.idx_last_emit = (previous_length == '0) || (idx_plus1 == previous_length);
  end

  assign repeat_count = group_count;
  assign byte_valid   = (previous_length != '0);
  assign text_byte    = byte_valid ? rd_a : 8'd0;
  assign group_last   = status.idx_last_emit;

endmodule
`default_nettype wire

// ===== rtl/aldc_ctrl.sv =====
`default_nettype none
module aldc_ctrl (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  end_of_input,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  input  wire aldc_pkg::aldc_status_t status,
  output aldc_pkg::aldc_cmd_t        cmd
);

  typedef enum logic [4:0] {
    S_IDLE     = 5'b00001,
    S_CMP_RD   = 5'b00010,
    S_CMP_CHK  = 5'b00100,
    S_EMIT_RD  = 5'b01000,
    S_EMIT_OUT = 5'b10000
  } aldc_state_t;

  aldc_state_t state, state_next;
  logic        flush, flush_next;
  logic        emit_final, emit_final_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      flush      <= 1'b0;
      emit_final <= 1'b0;
    end else begin
      state      <= state_next;
      flush      <= flush_next;
      emit_final <= emit_final_next;
    end
  end

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_EMIT_OUT);

  always_comb begin
    state_next      = state;
    flush_next      = flush;
    emit_final_next = emit_final;
    cmd             = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          if (end_of_input && status.cur_len_zero) begin
            if (status.have_prev) begin
              flush_next      = 1'b1;
              emit_final_next = 1'b1;
              cmd.idx_clear   = 1'b1;
              state_next      = S_EMIT_RD;
            end else begin
              cmd.clear_all = 1'b1;
            end
          end else if (end_of_input || status.is_newline) begin
            // A line is complete: first line, length change, empty repeat, or compare.
            flush_next = end_of_input;
            if (!status.have_prev) begin
              cmd.promote = 1'b1;
              if (end_of_input) begin
                emit_final_next = 1'b1;
                cmd.idx_clear   = 1'b1;
                state_next      = S_EMIT_RD;
              end
            end else if (status.len_mismatch) begin
              emit_final_next = 1'b0;
              cmd.idx_clear   = 1'b1;
              state_next      = S_EMIT_RD;
            end else if (status.cur_len_zero) begin
              cmd.count_inc = 1'b1;
            end else begin
              cmd.idx_clear = 1'b1;
              state_next    = S_CMP_RD;
            end
          end else begin
            cmd.store_byte = 1'b1;
          end
        end
      end
      S_CMP_RD: begin
        state_next = S_CMP_CHK;
      end
      S_CMP_CHK: begin
        if (status.pair_differ) begin
          emit_final_next = 1'b0;
          cmd.idx_clear   = 1'b1;
          state_next      = S_EMIT_RD;
        end else if (status.idx_last_cmp) begin
          cmd.count_inc = 1'b1;
          if (flush) begin
            emit_final_next = 1'b1;
            cmd.idx_clear   = 1'b1;
            state_next      = S_EMIT_RD;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = S_CMP_RD;
        end
      end
      S_EMIT_RD: begin
        cmd.rd_prev = 1'b1;
        state_next  = S_EMIT_OUT;
      end
      S_EMIT_OUT: begin
        cmd.rd_prev = 1'b1;
        if (out_ready) begin
          if (!status.idx_last_emit) begin
            cmd.idx_inc = 1'b1;
            state_next  = S_EMIT_RD;
          end else if (!emit_final) begin
            // The new line takes over as the previous line of the next group.
            cmd.promote = 1'b1;
            if (flush) begin
              emit_final_next = 1'b1;
              cmd.idx_clear   = 1'b1;
              state_next      = S_EMIT_RD;
            end else begin
              state_next = S_IDLE;
            end
          end else begin
            cmd.clear_all   = 1'b1;
            flush_next      = 1'b0;
            emit_final_next = 1'b0;
            state_next      = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire
